// File: sv/kac_pkg.sv
// Shared types, codes and reset constants for the keypad alarm controller.
`default_nettype none
package kac_pkg;

  localparam int KAC_CODE_KEYS = 3;

  localparam int SECRET_W    = 12;
  localparam int THRESH_W    = 10;
  localparam int INTERVAL_W  = 16;
  localparam int TRIES_W     = 4;
  localparam int KEY_W       = 4;
  localparam int SAMPLE_W    = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 16;

  localparam logic [SECRET_W-1:0]   SECRET_RST   = 12'h911;
  localparam logic [THRESH_W-1:0]   THRESH_RST   = 10'd100;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 16'd150;
  localparam logic [TRIES_W-1:0]    TRIES_RST    = 4'd2;

  localparam logic [KEY_W-1:0] KEY_A = 4'd10;
  localparam logic [KEY_W-1:0] KEY_C = 4'd12;
  localparam logic [KEY_W-1:0] KEY_D = 4'd13;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_READY  = 3'd1,
    MODE_ARMED  = 3'd2,
    MODE_ALARM  = 3'd3,
    MODE_LOCKED = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECRET    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_INTERVAL  = 2'd2,
    CFG_TRIES     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [SECRET_W-1:0]   secret_code;
    logic [THRESH_W-1:0]   motion_threshold;
    logic [INTERVAL_W-1:0] blink_interval;
    logic [TRIES_W-1:0]    allowed_wrong_tries;
  } cfg_t;

  typedef struct packed {
    logic              key_valid;
    logic [KEY_W-1:0]  key_code;
    logic [SAMPLE_W-1:0] motion_sample;
  } tick_t;

  typedef struct packed {
    mode_t      mode;
    logic       green_lamp;
    logic       red_lamp;
    logic       latch_open;
    logic       tone_start;
    logic [1:0] entered_count;
    logic       bad_code;
  } result_t;

endpackage
`default_nettype wire

// File: sv/kac_cfg.sv
// Configuration register file for the keypad alarm controller.
`default_nettype none
module kac_cfg
  import kac_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secret_code         <= SECRET_RST;
      cfg.motion_threshold    <= THRESH_RST;
      cfg.blink_interval      <= INTERVAL_RST;
      cfg.allowed_wrong_tries <= TRIES_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SECRET:    cfg.secret_code         <= cfg_data[SECRET_W-1:0];
        CFG_THRESHOLD: cfg.motion_threshold    <= cfg_data[THRESH_W-1:0];
        CFG_INTERVAL:  cfg.blink_interval      <= cfg_data[INTERVAL_W-1:0];
        CFG_TRIES:     cfg.allowed_wrong_tries <= cfg_data[TRIES_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/kac_ctrl.sv
// Mode state machine, code entry, wrong-try count and blink timer.
`default_nettype none
module kac_ctrl
  import kac_pkg::*;
#(
  parameter int CODE_KEYS = KAC_CODE_KEYS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  fire,
  input  wire tick_t tick,
  output result_t    result
);

  localparam int DIG_W = 4 * CODE_KEYS;
  localparam int CNT_W = $clog2(CODE_KEYS + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_KEYS);

  mode_t                 mode, mode_next;
  logic [DIG_W-1:0]      digits, digits_next;
  logic [CNT_W-1:0]      count, count_next;
  logic [TRIES_W-1:0]    wrong_tries, wrong_tries_next;
  logic [INTERVAL_W-1:0] blink_timer, blink_timer_next;
  logic                  blink_phase, blink_phase_next;
  logic                  red, red_next;
  logic                  latch, latch_next;
  logic                  tone, bad;

  logic [DIG_W-1:0]      secret_ext;
  logic [DIG_W+3:0]      shifted;
  logic [DIG_W-1:0]      appended;
  logic                  match, can_append;
  logic                  kv_a, kv_c, kv_d, kv_other;
  logic [CNT_W+1:0]      count_ext;

  // Secret is compared on its low 4*CODE_KEYS bits, zero filled above 12 bits.
  always_comb begin
    for (int i = 0; i < DIG_W; i++) begin
      secret_ext[i] = (i < SECRET_W) ? cfg.secret_code[i] : 1'b0;
    end
  end

  assign shifted    = {digits, tick.key_code};
  assign appended   = shifted[DIG_W-1:0];
  assign can_append = (count < CNT_FULL);
  assign match      = (count == CNT_FULL) && (digits == secret_ext);
  assign kv_a       = tick.key_valid && (tick.key_code == KEY_A);
  assign kv_c       = tick.key_valid && (tick.key_code == KEY_C);
  assign kv_d       = tick.key_valid && (tick.key_code == KEY_D);
  assign kv_other   = tick.key_valid && !kv_a && !kv_c && !kv_d;

  always_comb begin
    mode_next        = mode;
    digits_next      = digits;
    count_next       = count;
    wrong_tries_next = wrong_tries;
    blink_phase_next = blink_phase;
    red_next         = red;
    latch_next       = latch;
    tone             = 1'b0;
    bad              = 1'b0;
    blink_timer_next = (blink_timer != '1) ? blink_timer + 1'b1 : blink_timer;

    unique case (mode)
      MODE_READY: begin
        if (kv_d) begin
          mode_next = MODE_OFF;
        end else if (kv_c) begin
          digits_next = '0;
          count_next  = '0;
        end else if (kv_a) begin
          digits_next = '0;
          count_next  = '0;
          if (match) begin
            mode_next  = MODE_ARMED;
            red_next   = 1'b1;
            latch_next = 1'b0;
          end else begin
            bad = 1'b1;
          end
        end else if (tick.key_valid && can_append) begin
          digits_next = appended;
          count_next  = count + 1'b1;
        end
      end
      MODE_ARMED: begin
        if (kv_c) begin
          digits_next = '0;
          count_next  = '0;
        end else if (kv_a) begin
          digits_next = '0;
          count_next  = '0;
          if (match) begin
            mode_next  = MODE_READY;
            red_next   = 1'b0;
            latch_next = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end else if (kv_other && can_append) begin
          digits_next = appended;
          count_next  = count + 1'b1;
        end
        // Motion is checked after the key unless the key disarmed.
        if (!(kv_a && match) && (tick.motion_sample > cfg.motion_threshold)) begin
          mode_next        = MODE_ALARM;
          digits_next      = '0;
          count_next       = '0;
          wrong_tries_next = '0;
          blink_phase_next = 1'b0;
        end
      end
      MODE_ALARM, MODE_LOCKED: begin
        if (blink_timer_next >= cfg.blink_interval) begin
          blink_timer_next = '0;
          blink_phase_next = !blink_phase;
          red_next         = !blink_phase;
          tone             = 1'b1;
        end
        if (mode == MODE_ALARM) begin
          if (kv_c) begin
            digits_next = '0;
            count_next  = '0;
          end else if (kv_a) begin
            if (match) begin
              mode_next   = MODE_READY;
              digits_next = '0;
              count_next  = '0;
              red_next    = 1'b0;
              latch_next  = 1'b1;
            end else if (wrong_tries < cfg.allowed_wrong_tries) begin
              digits_next      = '0;
              count_next       = '0;
              wrong_tries_next = wrong_tries + 1'b1;
              bad              = 1'b1;
            end else begin
              mode_next        = MODE_LOCKED;
              blink_phase_next = 1'b0;
              bad              = 1'b1;
            end
          end else if (kv_other && can_append) begin
            digits_next = appended;
            count_next  = count + 1'b1;
          end
        end
      end
      default: begin
        // Off, and any stray code, behaves as off.
        mode_next = MODE_OFF;
        if (kv_d) begin
          mode_next   = MODE_READY;
          digits_next = '0;
          count_next  = '0;
          red_next    = 1'b0;
          latch_next  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_OFF;
      digits      <= '0;
      count       <= '0;
      wrong_tries <= '0;
      blink_timer <= '0;
      blink_phase <= 1'b0;
      red         <= 1'b0;
      latch       <= 1'b0;
    end else if (fire) begin
      mode        <= mode_next;
      digits      <= digits_next;
      count       <= count_next;
      wrong_tries <= wrong_tries_next;
      blink_timer <= blink_timer_next;
      blink_phase <= blink_phase_next;
      red         <= red_next;
      latch       <= latch_next;
    end
  end

  assign count_ext = {2'b00, count_next};

  always_comb begin
    result.mode          = mode_next;
    result.green_lamp    = (mode_next == MODE_READY);
    result.red_lamp      = red_next;
    result.latch_open    = latch_next;
    result.tone_start    = tone;
    result.entered_count = count_ext[1:0];
    result.bad_code      = bad;
  end

  a_locked_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_LOCKED) |=> (mode == MODE_LOCKED))
    else $error("locked mode left without reset");

  a_ready_latch: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_READY) |-> (latch && !red))
    else $error("ready mode with latch closed or red lamp on");

  a_armed_outputs: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_ARMED) |-> (!latch && red))
    else $error("armed mode with latch open or red lamp off");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("code entry holds more keys than the code length");

  a_tone_mode: assert property (@(posedge clk) disable iff (rst)
    (fire && tone) |-> ((mode == MODE_ALARM) || (mode == MODE_LOCKED)))
    else $error("tone pulse outside alarm and locked modes");

endmodule
`default_nettype wire

// File: sv/keypad_alarm_controller_unit.sv
// Top level of the keypad alarm controller: input register, control, result register.
//
//  channel | dir | handshake         | contents
//  s       | in  | s_tvalid/s_tready | one tick: key and motion sample
//  m       | out | m_tvalid/m_tready | mode, lamps, latch, tone, count, bad code
//  cfg     | in  | cfg_wr_en         | register index and write data, no wait
//
// A tick is taken every cycle unless m stalls; it passes input, then result register.
// The mode state updates as the tick leaves the input register, so the next tick
// in the register already sees it. rst clears modes, counters and both valid flags;
// configuration returns to its defaults. A stalled m side holds the result and the
// input register; s_tready stays high while the input register can move on.
`default_nettype none
module keypad_alarm_controller_unit
  import kac_pkg::*;
#(
  parameter int CODE_KEYS = KAC_CODE_KEYS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [0] key_valid, [4:1] key_code, [14:5] motion_sample, [15] zero
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [2:0] mode, [3] green_lamp, [4] red_lamp, [5] latch_open, [6] tone_start,
  // [8:7] entered_count, [9] bad_code, [15:10] zero
  output logic [M_TDATA_W-1:0]       m_tdata,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  tick_t   tick;
  result_t result;
  logic    in_valid;
  logic    fire;

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      tick.key_valid     <= s_tdata[0];
      tick.key_code      <= s_tdata[4:1];
      tick.motion_sample <= s_tdata[14:5];
    end
  end

  kac_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kac_ctrl #(
    .CODE_KEYS (CODE_KEYS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .tick   (tick),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Hold the result beat until it is taken.
  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {6'b000000, result.bad_code, result.entered_count, result.tone_start,
                  result.latch_open, result.red_lamp, result.green_lamp, result.mode};
    end
  end

endmodule
`default_nettype wire
